// ===== rtl/irfd_pkg.sv =====
// ----------------------------------------------------------------------------
// irfd_pkg
// Shared types and constants for the delimited frame receiver with XOR check.
// ----------------------------------------------------------------------------
package irfd_pkg;

  localparam logic [7:0] TOK_START   = 8'h2A;
  localparam logic [7:0] TOK_CHECK   = 8'h40;
  localparam logic [7:0] TOK_NEWLINE = 8'h0A;
  localparam int unsigned MIN_SPAN   = 3;

  localparam logic [2:0] ST_GOOD      = 3'd0;
  localparam logic [2:0] ST_BAD_READ  = 3'd1;
  localparam logic [2:0] ST_NO_START  = 3'd2;
  localparam logic [2:0] ST_TOO_SHORT = 3'd3;
  localparam logic [2:0] ST_NO_TOKEN  = 3'd4;
  localparam logic [2:0] ST_MISMATCH  = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FETCH,
    S_SHOW_DATA,
    S_SHOW_STATUS
  } state_t;

  typedef struct packed {
    logic accept;
    logic check;
    logic fetch;
    logic clear;
    logic show_data;
  } cmd_t;

  typedef struct packed {
    logic closes;
    logic payload_ok;
    logic rd_last;
  } flags_t;

endpackage

// ===== rtl/irfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// irfd_ctrl
// Controller: sequences byte collection, frame check and result emission.
// ----------------------------------------------------------------------------
module irfd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  irfd_pkg::flags_t flags,
  output irfd_pkg::cmd_t  cmd
);

  irfd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= irfd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      irfd_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && flags.closes) begin
          state_next = irfd_pkg::S_CHECK;
        end
      end
      irfd_pkg::S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = flags.payload_ok ? irfd_pkg::S_FETCH : irfd_pkg::S_SHOW_STATUS;
      end
      irfd_pkg::S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = irfd_pkg::S_SHOW_DATA;
      end
      irfd_pkg::S_SHOW_DATA: begin
        out_valid     = 1'b1;
        cmd.show_data = 1'b1;
        if (out_ready) begin
          if (flags.rd_last) begin
            cmd.clear  = 1'b1;
            state_next = irfd_pkg::S_IDLE;
          end else begin
            state_next = irfd_pkg::S_FETCH;
          end
        end
      end
      irfd_pkg::S_SHOW_STATUS: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.clear  = 1'b1;
          state_next = irfd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = irfd_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/irfd_datapath.sv =====
// ----------------------------------------------------------------------------
// irfd_datapath
// Datapath: frame buffer, token tracking, running checksum and result fields.
// ----------------------------------------------------------------------------
module irfd_datapath #(
  parameter int FRAME_BYTES = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  irfd_pkg::cmd_t   cmd,
  output irfd_pkg::flags_t flags,
  input  logic [7:0]       rx_byte,
  output logic [2:0]       status,
  output logic [7:0]       payload_byte,
  output logic             has_data,
  output logic             last
);

  localparam int CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W = $clog2(FRAME_BYTES);

  logic [7:0]       mem [FRAME_BYTES];
  logic [CNT_W-1:0] count;
  logic             first_zero;
  logic             start_found;
  logic [IDX_W-1:0] start_pos;
  logic             mark_found;
  logic [IDX_W-1:0] mark_pos;
  logic [7:0]       cs;
  logic             cs_done;
  logic             after_found;
  logic [7:0]       after_byte;
  logic [2:0]       status_reg;
  logic [IDX_W-1:0] rd_ptr;
  logic [7:0]       rd_data;
  logic             rd_last;

  logic             start_hit;
  logic             is_mark;
  logic [2:0]       status_calc;
  logic [CNT_W-1:0] span;

  assign start_hit = start_found || (rx_byte == irfd_pkg::TOK_START);
  assign is_mark   = (rx_byte == irfd_pkg::TOK_CHECK) && !mark_found;
  assign span      = count - CNT_W'(start_pos);

  always_comb begin
    if (first_zero) begin
      status_calc = irfd_pkg::ST_BAD_READ;
    end else if (!start_found) begin
      status_calc = irfd_pkg::ST_NO_START;
    end else if (span <= CNT_W'(irfd_pkg::MIN_SPAN)) begin
      status_calc = irfd_pkg::ST_TOO_SHORT;
    end else if (!mark_found || (mark_pos <= start_pos) || !after_found) begin
      status_calc = irfd_pkg::ST_NO_TOKEN;
    end else if (cs != after_byte) begin
      status_calc = irfd_pkg::ST_MISMATCH;
    end else begin
      status_calc = irfd_pkg::ST_GOOD;
    end
  end

  assign flags.closes     = (rx_byte == irfd_pkg::TOK_NEWLINE) ||
                            (count == CNT_W'(FRAME_BYTES - 1));
  assign flags.payload_ok = (status_calc == irfd_pkg::ST_GOOD) &&
                            (({1'b0, start_pos} + 1'b1) != {1'b0, mark_pos});
  assign flags.rd_last    = rd_last;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem[count[IDX_W-1:0]] <= rx_byte;
    end
    if (cmd.fetch) begin
      rd_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count       <= '0;
      first_zero  <= 1'b0;
      start_found <= 1'b0;
      mark_found  <= 1'b0;
      cs_done     <= 1'b0;
      after_found <= 1'b0;
      cs          <= '0;
    end else if (cmd.accept) begin
      count <= count + 1'b1;
      if (count == '0) begin
        first_zero <= (rx_byte == 8'h00);
      end
      if (!start_found && (rx_byte == irfd_pkg::TOK_START)) begin
        start_found <= 1'b1;
        start_pos   <= count[IDX_W-1:0];
      end
      if (mark_found && !after_found) begin
        after_found <= 1'b1;
        after_byte  <= rx_byte;
      end
      if (is_mark) begin
        mark_found <= 1'b1;
        mark_pos   <= count[IDX_W-1:0];
      end
      if (start_hit && !cs_done) begin
        if (rx_byte == 8'h00) begin
          cs_done <= 1'b1;
        end else begin
          cs <= cs ^ rx_byte;
          if (is_mark) begin
            cs_done <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      status_reg <= status_calc;
      rd_ptr     <= IDX_W'({1'b0, start_pos} + 1'b1);
    end else if (cmd.fetch) begin
      rd_ptr  <= rd_ptr + 1'b1;
      rd_last <= (({1'b0, rd_ptr} + 1'b1) == {1'b0, mark_pos});
    end
  end

  assign status       = cmd.show_data ? irfd_pkg::ST_GOOD : status_reg;
  assign payload_byte = cmd.show_data ? rd_data : 8'h00;
  assign has_data     = cmd.show_data;
  assign last         = cmd.show_data ? rd_last : 1'b1;

endmodule

// ===== rtl/ir_frame_deframer_xor_check.sv =====
// ----------------------------------------------------------------------------
// ir_frame_deframer_xor_check
// Receives bytes into a frame buffer and checks each closed frame.
// ----------------------------------------------------------------------------
// A byte is taken whenever one is offered while a frame is open. A frame
// closes on a newline byte or when FRAME_BYTES bytes are held; the block
// then stops taking bytes, runs the check, and gives either one status beat
// or one beat per payload byte. Each payload beat first reads the frame
// buffer and then presents the beat, which holds while the output stalls.
// Start, checksum token and XOR are tracked as bytes arrive, so no scan is
// needed.
module ir_frame_deframer_xor_check #(
  parameter int FRAME_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] status,
  output logic [7:0] payload_byte,
  output logic       has_data,
  output logic       last
);

  irfd_pkg::cmd_t   cmd;
  irfd_pkg::flags_t flags;

  irfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .flags     (flags),
    .cmd       (cmd)
  );

  irfd_datapath #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .flags        (flags),
    .rx_byte      (rx_byte),
    .status       (status),
    .payload_byte (payload_byte),
    .has_data     (has_data),
    .last         (last)
  );

endmodule

// ===== rtl/irfd_checker.sv =====
// ----------------------------------------------------------------------------
// irfd_checker
// Port-level checks for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module irfd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic [7:0] payload_byte,
  input logic       has_data,
  input logic       last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({status, payload_byte, has_data, last}))
    else $error("Output beat changed while stalled.");

  a_status_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_data |-> last && (payload_byte == 8'h00))
    else $error("Status beat is not a final beat with zero payload.");

  a_data_good: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_data |-> status == irfd_pkg::ST_GOOD)
    else $error("Payload beat carries a failure status.");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("Input taken while a frame is being reported.");

endmodule

bind ir_frame_deframer_xor_check irfd_checker u_irfd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .payload_byte (payload_byte),
  .has_data     (has_data),
  .last         (last)
);

// ===== verif/ir_frame_deframer_xor_check_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ir_frame_deframer_xor_check_tb
// Self-checking bench for the delimited frame receiver with XOR checksum.
// ----------------------------------------------------------------------------
// A short table of hand-built frames covers each status code, an empty good
// payload, and zero and all-ones payload bytes. Random frames follow: mostly
// well-formed frames with random payloads filling up to the full buffer, mixed
// with corrupted checksums, misplaced or missing tokens, and noise.
// Every byte accepted is fed to a frame predictor in the bench, and every
// output beat is compared with the oldest predicted beat. The sender works in
// random bursts and the receiver stalls on a changing pattern.
// ----------------------------------------------------------------------------
module ir_frame_deframer_xor_check_tb;

  localparam int FRAME_BYTES = 32;
  localparam int RANDOM_BYTES = 280;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] payload_byte;
    logic       has_data;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [7:0] data;
    bit         typed;
    logic [2:0] status;
  } dir_row_t;

  localparam dir_row_t DIRECTED [24] = '{
    {irfd_pkg::TOK_NEWLINE, 1'b1, irfd_pkg::ST_NO_START},
    {8'h00, 1'b0, irfd_pkg::ST_GOOD},
    {irfd_pkg::TOK_NEWLINE, 1'b1, irfd_pkg::ST_BAD_READ},
    {irfd_pkg::TOK_START, 1'b0, irfd_pkg::ST_GOOD},
    {8'h41, 1'b0, irfd_pkg::ST_GOOD},
    {irfd_pkg::TOK_NEWLINE, 1'b1, irfd_pkg::ST_TOO_SHORT},
    {irfd_pkg::TOK_START, 1'b0, irfd_pkg::ST_GOOD},
    {8'h41, 1'b0, irfd_pkg::ST_GOOD},
    {8'h42, 1'b0, irfd_pkg::ST_GOOD},
    {irfd_pkg::TOK_NEWLINE, 1'b1, irfd_pkg::ST_NO_TOKEN},
    {irfd_pkg::TOK_START, 1'b0, irfd_pkg::ST_GOOD},
    {irfd_pkg::TOK_CHECK, 1'b0, irfd_pkg::ST_GOOD},
    {8'h00, 1'b0, irfd_pkg::ST_GOOD},
    {irfd_pkg::TOK_NEWLINE, 1'b1, irfd_pkg::ST_MISMATCH},
    {irfd_pkg::TOK_START, 1'b0, irfd_pkg::ST_GOOD},
    {irfd_pkg::TOK_CHECK, 1'b0, irfd_pkg::ST_GOOD},
    {irfd_pkg::TOK_START ^ irfd_pkg::TOK_CHECK, 1'b0, irfd_pkg::ST_GOOD},
    {irfd_pkg::TOK_NEWLINE, 1'b1, irfd_pkg::ST_GOOD},
    {irfd_pkg::TOK_START, 1'b0, irfd_pkg::ST_GOOD},
    {8'h00, 1'b0, irfd_pkg::ST_GOOD},
    {8'hFF, 1'b0, irfd_pkg::ST_GOOD},
    {irfd_pkg::TOK_CHECK, 1'b0, irfd_pkg::ST_GOOD},
    {irfd_pkg::TOK_START, 1'b0, irfd_pkg::ST_GOOD},
    {irfd_pkg::TOK_NEWLINE, 1'b0, irfd_pkg::ST_GOOD}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] status;
  logic [7:0] payload_byte;
  logic       has_data;
  logic       last;

  beat_t       pending_beats [$];
  beat_t       want;
  logic [7:0]  rx_frame [FRAME_BYTES];
  int unsigned frame_fill = 0;
  int unsigned status_seen [6] = '{default: 0};
  int unsigned frames_closed = 0;
  int unsigned bytes_sent = 0;
  int unsigned random_bytes = 0;
  int unsigned beats_checked = 0;
  int unsigned data_beats = 0;
  int unsigned fails = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;
  logic [1:0]  ready_mode = 2'd0;
  logic [31:0] ready_pat = 32'hFFFF_FFFF;
  bit          paused = 1'b0;

  ir_frame_deframer_xor_check #(
    .FRAME_BYTES(FRAME_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .payload_byte(payload_byte),
    .has_data(has_data),
    .last(last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic beat_t make_beat(input logic [2:0] st, input logic [7:0] data,
                                      input logic has, input logic lst);
    beat_t b;
    b.status = st;
    b.payload_byte = data;
    b.has_data = has;
    b.last = lst;
    return b;
  endfunction

  function automatic void queue_status(input logic [2:0] st, input bit keep);
    if (keep) pending_beats.push_back(make_beat(st, 8'h00, 1'b0, 1'b1));
    status_seen[st]++;
  endfunction

  function automatic void check_closed_frame(input bit keep);
    int unsigned n;
    int unsigned start;
    int unsigned mark;
    logic [7:0] xsum;
    n = frame_fill;
    start = n;
    mark = n;
    frames_closed++;
    for (int unsigned i = 0; i < n; i++) begin
      if (start == n && rx_frame[i] == irfd_pkg::TOK_START) start = i;
      if (mark == n && rx_frame[i] == irfd_pkg::TOK_CHECK) mark = i;
    end
    if (rx_frame[0] == 8'h00) begin
      queue_status(irfd_pkg::ST_BAD_READ, keep);
    end else if (start == n) begin
      queue_status(irfd_pkg::ST_NO_START, keep);
    end else if (n - start <= irfd_pkg::MIN_SPAN) begin
      queue_status(irfd_pkg::ST_TOO_SHORT, keep);
    end else if (mark == n || mark <= start || mark + 1 >= n) begin
      queue_status(irfd_pkg::ST_NO_TOKEN, keep);
    end else begin
      xsum = 8'h00;
      for (int unsigned i = start; i <= mark; i++) begin
        if (rx_frame[i] == 8'h00) break;
        xsum ^= rx_frame[i];
      end
      if (xsum != rx_frame[mark + 1]) begin
        queue_status(irfd_pkg::ST_MISMATCH, keep);
      end else if (mark == start + 1) begin
        queue_status(irfd_pkg::ST_GOOD, keep);
      end else begin
        status_seen[irfd_pkg::ST_GOOD]++;
        for (int unsigned i = start + 1; i < mark; i++) begin
          if (keep) begin
            pending_beats.push_back(make_beat(irfd_pkg::ST_GOOD, rx_frame[i], 1'b1,
                                              i + 1 == mark));
          end
        end
      end
    end
  endfunction

  function automatic void deframe_byte(input logic [7:0] b, input bit keep);
    rx_frame[frame_fill] = b;
    frame_fill++;
    if (b == irfd_pkg::TOK_NEWLINE || frame_fill >= FRAME_BYTES) begin
      check_closed_frame(keep);
      frame_fill = 0;
    end
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] v;
    do v = 8'($urandom);
    while (v == irfd_pkg::TOK_START || v == irfd_pkg::TOK_CHECK ||
           v == irfd_pkg::TOK_NEWLINE);
    return v;
  endfunction

  function automatic logic [7:0] payload_fill();
    logic [7:0] v;
    if ($urandom_range(0, 7) == 0) return 8'h00;
    do v = 8'($urandom); while (v == irfd_pkg::TOK_CHECK || v == irfd_pkg::TOK_NEWLINE);
    return v;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed, input beat_t typed_beat);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      case ($urandom_range(0, 5))
        0, 1: gap = 0;
        2: gap = $urandom_range(20, 60);
        default: gap = $urandom_range(1, 8);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    bytes_sent++;
    deframe_byte(b, !typed);
    if (typed) pending_beats.push_back(typed_beat);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_beats.size() != 0);
  endtask

  task automatic send_random_frame();
    logic [7:0] fr [$];
    logic [7:0] xsum;
    int unsigned kind;
    int unsigned pre;
    int unsigned plen;
    int unsigned len;
    bit ended;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      pre = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      if ($urandom_range(0, 7) == 0) plen = $urandom_range(0, 1) ? 29 : $urandom_range(20, 28);
      else plen = $urandom_range(0, 8);
      if (pre + plen > 29) plen = 29 - pre;
      repeat (pre) fr.push_back(plain_byte());
      fr.push_back(irfd_pkg::TOK_START);
      repeat (plen) fr.push_back(payload_fill());
      fr.push_back(irfd_pkg::TOK_CHECK);
      xsum = 8'h00;
      ended = 1'b0;
      for (int unsigned i = pre; i < fr.size(); i++) begin
        if (fr[i] == 8'h00) ended = 1'b1;
        if (!ended) xsum ^= fr[i];
      end
      if (kind >= 55) xsum ^= 8'(1 << $urandom_range(0, 7));
      fr.push_back(xsum);
      repeat ($urandom_range(0, 2)) if (fr.size() < FRAME_BYTES - 1) fr.push_back(plain_byte());
      if (fr.size() < FRAME_BYTES) fr.push_back(irfd_pkg::TOK_NEWLINE);
    end else if (kind < 85) begin
      len = $urandom_range(1, FRAME_BYTES);
      repeat (len) fr.push_back(8'($urandom));
      if ($urandom_range(0, 3) == 0) fr[0] = 8'h00;
      if (len < FRAME_BYTES) fr[len - 1] = irfd_pkg::TOK_NEWLINE;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          fr.push_back(irfd_pkg::TOK_START);
          repeat ($urandom_range(0, 2)) fr.push_back(plain_byte());
        end
        1: begin
          fr.push_back(irfd_pkg::TOK_CHECK);
          fr.push_back(plain_byte());
          fr.push_back(irfd_pkg::TOK_START);
          repeat (3) fr.push_back(plain_byte());
          fr.push_back(irfd_pkg::TOK_CHECK);
          fr.push_back(8'h00);
        end
        2: begin
          repeat (FRAME_BYTES - 4) fr.push_back(plain_byte());
          fr.push_back(irfd_pkg::TOK_START);
          fr.push_back(plain_byte());
          fr.push_back(plain_byte());
          fr.push_back(irfd_pkg::TOK_CHECK);
        end
        default: begin
          fr.push_back(irfd_pkg::TOK_START);
          repeat ($urandom_range(3, 6)) fr.push_back(plain_byte());
        end
      endcase
      if (fr.size() < FRAME_BYTES) fr.push_back(irfd_pkg::TOK_NEWLINE);
    end
    foreach (fr[i]) begin
      send_byte(fr[i], 1'b0, '0);
      random_bytes++;
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (cycle_count[7:0] == 8'd0) begin
        ready_mode <= 2'($urandom_range(0, 3));
        ready_pat <= $urandom;
      end
      case (ready_mode)
        2'd2: out_ready <= ready_pat[cycle_count[4:0]];
        2'd3: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_beats.size() == 0) begin
        $error("beat with nothing pending: status %0d, payload_byte %02h, has_data %0b, last %0b",
               status, payload_byte, has_data, last);
        fails++;
      end else begin
        want = pending_beats.pop_front();
        beats_checked++;
        if (want.has_data) data_beats++;
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fails++;
        end
        if (payload_byte !== want.payload_byte) begin
          $error("payload_byte: expected %02h, got %02h", want.payload_byte, payload_byte);
          fails++;
        end
        if (has_data !== want.has_data) begin
          $error("has_data: expected %0b, got %0b", want.has_data, has_data);
          fails++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[ir_frame_deframer_xor_check] ERROR");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    rx_byte <= 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED[i]) begin
      send_byte(DIRECTED[i].data, DIRECTED[i].typed,
                make_beat(DIRECTED[i].status, 8'h00, 1'b0, 1'b1));
    end
    drain_results();
    while (random_bytes < RANDOM_BYTES) begin
      send_random_frame();
      if (!paused && random_bytes >= RANDOM_BYTES / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
    drain_results();
    repeat (80) @(posedge clk);
    $display("Sent %0d bytes in %0d closed frames; checked %0d beats, %0d of them payload.",
             bytes_sent, frames_closed, beats_checked, data_beats);
    $display("Frame outcomes: good %0d, bad read %0d, no start %0d, too short %0d, %s %0d, %s %0d.",
             status_seen[irfd_pkg::ST_GOOD], status_seen[irfd_pkg::ST_BAD_READ],
             status_seen[irfd_pkg::ST_NO_START], status_seen[irfd_pkg::ST_TOO_SHORT],
             "token missing", status_seen[irfd_pkg::ST_NO_TOKEN],
             "mismatch", status_seen[irfd_pkg::ST_MISMATCH]);
    if (fails == 0) begin
      $display("[ir_frame_deframer_xor_check] OK");
    end else begin
      $display("[ir_frame_deframer_xor_check] ERROR");
    end
    $finish;
  end

endmodule
